FILE: rtl/fpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpw_pkg: fuel pulse width types and constants
// Field widths, register indexes, fixed-point constants and the structs
// shared by the configuration block, the pipeline and the back end.
// ----------------------------------------------------------------------------
package fpw_pkg;

	// field widths
	localparam int CELL_W   = 16;
	localparam int MAP_W    = 12;
	localparam int IAT_W    = 12;
	localparam int CORR_W   = 16;
	localparam int LPCT_W   = 10;
	localparam int PW_W     = 15;
	localparam int REQ_W    = 13;
	localparam int PRESS_W  = 14;
	localparam int FLOW_W   = 11;
	localparam int LIM_W    = 10;
	localparam int LIMUS_W  = 15;

	// internal widths
	localparam int VE_W     = 14;
	localparam int T_W      = 16;
	localparam int K_W      = 29;
	localparam int B_W      = 28;
	localparam int DIR_W    = 27;
	localparam int P_W      = 38;
	localparam int NUM1_W   = 62;
	localparam int DEN1_W   = 36;
	localparam int M_W      = 57;
	localparam int NUM2_W   = 41;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_VE_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_FUEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAIL_PRESSURE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATED_PRESSURE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INJECTOR_FLOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIMIT    = 3'd5;

	// fixed-point constants
	localparam int VE_MAX      = 15000;
	localparam int MAP_MIN     = 200;
	localparam int T_OFS       = 27315;
	localparam int T_MIN       = 25000;
	localparam int AIR_K       = 29315;
	localparam int D_SCALE     = 1000000;
	localparam int FLOW_GAIN   = 220;
	localparam int PRESS_MIN   = 50;
	localparam int FLOW_MIN    = 10;
	localparam int LIM_MIN     = 10;
	localparam int LIM_MAX     = 300;
	localparam int LIM_SCALE   = 100;
	localparam int PW_MIN      = 1000;
	localparam int DIRECT_GAIN = 2560;
	localparam int LAUNCH_BASE = 1000;
	localparam int LAUNCH_MIN  = 1;
	localparam int DIV_125     = 125;
	localparam logic [33:0] RECIP_125 = 34'd8796093022;  // floor(2^40 / 125)
	localparam int RECIP_SH    = 40;
	localparam int P_SAT_BIT   = 23;   // 2^23 / 256 is above any pulse limit

	typedef struct packed {
		logic               ve_mode;
		logic [REQ_W-1:0]   req;
		logic [FLOW_W-1:0]  flow;
		logic [K_W-1:0]     k;
		logic [LIMUS_W-1:0] lim_us;
		logic               busy;
	} cfg_t;

	typedef struct packed {
		logic signed [CELL_W-1:0] disp;
		logic [DIR_W-1:0]         dir;
		logic [CORR_W-1:0]        corr;
		logic                     launch;
		logic [LPCT_W-1:0]        lpct;
		logic                     cut;
	} side_t;

endpackage

FILE: rtl/fpw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpw_cfg: configuration registers and pressure factor
// Holds the registers and, after reset or any write, works out the flow
// factor 220 * isqrt(rated * 2^32 / rail) with a bit-serial divider and a
// two-bits-per-step square root.
// ----------------------------------------------------------------------------
module fpw_cfg import fpw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;

	localparam int SH_W   = PRESS_W + 32;
	localparam int ROOT_W = SH_W / 2;
	localparam int SREM_W = ROOT_W + 2;

	logic               ve_mode_q;
	logic [REQ_W-1:0]   req_q;
	logic [PRESS_W-1:0] rail_q;
	logic [PRESS_W-1:0] rated_q;
	logic [FLOW_W-1:0]  flow_q;
	logic [LIM_W-1:0]   lim_q;
	logic [K_W-1:0]     k_q;

	logic [2:0]         state_q;
	logic [5:0]         cnt_q;
	logic [SH_W-1:0]    sh_q;
	logic [PRESS_W-1:0] drem_q;
	logic [SREM_W-1:0]  srem_q;
	logic [ROOT_W-1:0]  root_q;

	logic [PRESS_W-1:0] rail_f;
	logic [PRESS_W-1:0] rated_f;
	logic [FLOW_W-1:0]  flow_f;
	logic [LIM_W-1:0]   lim_f;
	logic [PRESS_W:0]   drem_w;
	logic               dtake;
	logic [SREM_W-1:0]  srem_w;
	logic [SREM_W-1:0]  strial;
	logic               stake;
	logic [K_W-1:0]     k_w;

	assign rail_f  = (rail_q < PRESS_W'(PRESS_MIN)) ? PRESS_W'(PRESS_MIN) : rail_q;
	assign rated_f = (rated_q < PRESS_W'(PRESS_MIN)) ? PRESS_W'(PRESS_MIN) : rated_q;
	assign flow_f  = (flow_q < FLOW_W'(FLOW_MIN)) ? FLOW_W'(FLOW_MIN) : flow_q;
	assign lim_f   = (lim_q < LIM_W'(LIM_MIN)) ? LIM_W'(LIM_MIN) :
	                 (lim_q > LIM_W'(LIM_MAX)) ? LIM_W'(LIM_MAX) : lim_q;

	assign drem_w = {drem_q, sh_q[SH_W-1]};
	assign dtake  = drem_w >= {1'b0, rail_f};
	assign srem_w = {srem_q[SREM_W-3:0], sh_q[SH_W-1:SH_W-2]};
	assign strial = {root_q, 2'b01};
	assign stake  = srem_w >= strial;
	assign k_w    = K_W'(root_q) * K_W'(FLOW_GAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ve_mode_q <= 1'b1;
			req_q     <= REQ_W'(1000);
			rail_q    <= PRESS_W'(300);
			rated_q   <= PRESS_W'(300);
			flow_q    <= FLOW_W'(220);
			lim_q     <= LIM_W'(200);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VE_MODE:        ve_mode_q <= cfg_data[0];
				REG_REQUIRED_FUEL:  req_q     <= cfg_data[REQ_W-1:0];
				REG_RAIL_PRESSURE:  rail_q    <= cfg_data[PRESS_W-1:0];
				REG_RATED_PRESSURE: rated_q   <= cfg_data[PRESS_W-1:0];
				REG_INJECTOR_FLOW:  flow_q    <= cfg_data[FLOW_W-1:0];
				REG_PULSE_LIMIT:    lim_q     <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else if (cfg_valid) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					state_q <= ST_DIV;
					cnt_q   <= 6'(SH_W - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= 6'(ROOT_W - 1);
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_MUL:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// quotient shifts into sh_q, then the square root consumes it two bits a step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				sh_q   <= {rated_f, 32'd0};
				drem_q <= '0;
				srem_q <= '0;
				root_q <= '0;
			end
			ST_DIV: begin
				drem_q <= dtake ? PRESS_W'(drem_w - {1'b0, rail_f}) : drem_w[PRESS_W-1:0];
				sh_q   <= {sh_q[SH_W-2:0], dtake};
			end
			ST_SQRT: begin
				srem_q <= stake ? (srem_w - strial) : srem_w;
				root_q <= {root_q[ROOT_W-2:0], stake};
				sh_q   <= {sh_q[SH_W-3:0], 2'b00};
			end
			ST_MUL: k_q <= k_w;
			default: ;
		endcase
	end

	assign cfg.ve_mode = ve_mode_q;
	assign cfg.req     = req_q;
	assign cfg.flow    = flow_f;
	assign cfg.k       = k_q;
	assign cfg.lim_us  = LIMUS_W'(lim_f) * LIMUS_W'(LIM_SCALE);
	assign cfg.busy    = state_q != ST_IDLE;

endmodule

FILE: rtl/fpw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpw_div: pipelined restoring divider
// One quotient bit per stage, Q_W + 1 register stages, side data carried
// along. The caller keeps the numerator below den * 2^Q_W.
// ----------------------------------------------------------------------------
module fpw_div #(
	parameter int NUM_W = 62,
	parameter int DEN_W = 36,
	parameter int Q_W   = 28,
	parameter int SB_W  = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_vld,
	output logic [Q_W-1:0]   out_q,
	output logic [SB_W-1:0]  out_sb
);

	localparam int WW = DEN_W + Q_W;

	logic [WW-1:0]    rem_s [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic [Q_W-1:0]   q_s   [0:Q_W];
	logic [SB_W-1:0]  sb_s  [0:Q_W];
	logic [Q_W:0]     vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[Q_W-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0] <= WW'(in_num);
			den_s[0] <= in_den;
			q_s[0]   <= '0;
			sb_s[0]  <= in_sb;
		end
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		localparam int J = Q_W - 1 - i;
		logic [WW-1:0] trial;
		logic          take;

		assign trial = WW'(den_s[i]) << J;
		assign take  = rem_s[i] >= trial;

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[i+1]    <= take ? (rem_s[i] - trial) : rem_s[i];
				q_s[i+1]      <= q_s[i] | (Q_W'(take) << J);
				den_s[i+1]    <= den_s[i];
				sb_s[i+1]     <= sb_s[i];
			end
		end
	end

	assign out_vld = vld_s[Q_W];
	assign out_q   = q_s[Q_W];
	assign out_sb  = sb_s[Q_W];

endmodule

FILE: rtl/fpw_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpw_post: correction, launch enrichment and clamping
// Six register stages: correction multiply, saturation, launch multiply,
// divide by 1000 through a reciprocal with one correction step, and the
// final clamp and fuel cut into the output register.
// ----------------------------------------------------------------------------
module fpw_post import fpw_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ce,
	input  cfg_t                     cfg,
	input  logic                     in_vld,
	input  logic [P_W-1:0]           in_q,
	input  side_t                    in_sb,
	output logic                     out_vld,
	output logic [PW_W-1:0]          pulse_width_us,
	output logic signed [CELL_W-1:0] ve_display
);

	localparam int PC_W = P_W + CORR_W;
	localparam int PS_W = P_SAT_BIT + 1;
	localparam int MF_W = LPCT_W + 1;
	localparam int V_W  = PS_W + MF_W;
	localparam int U_W  = V_W - 3;
	localparam int PR_W = U_W + 34;
	localparam int QE_W = PR_W - RECIP_SH;
	localparam int R_W  = U_W + 1;
	localparam int PL_W = QE_W;
	localparam int W_W  = PL_W - 8;

	logic [5:0] vld_s;

	logic [PC_W-1:0] pc_s1;
	side_t           sb_s1;
	logic [PS_W-1:0] ps_s2;
	logic            en_s2;
	logic [MF_W-1:0] mf_s2;
	side_t           sb_s2;
	logic [V_W-1:0]  v_s3;
	logic [PS_W-1:0] ps_s3;
	logic            en_s3;
	side_t           sb_s3;
	logic [PR_W-1:0] prod_s4;
	logic [U_W-1:0]  u_s4;
	logic [PS_W-1:0] ps_s4;
	logic            en_s4;
	side_t           sb_s4;
	logic [PL_W-1:0] pl_s5;
	side_t           sb_s5;
	logic [PW_W-1:0] pw_s6;
	logic signed [CELL_W-1:0] disp_s6;

	logic [P_W-1:0]    p_sel;
	logic [PC_W-13:0]  pc_sh;
	logic [U_W-1:0]    u_c;
	logic [QE_W-1:0]   qe_c;
	logic [R_W-1:0]    r_c;
	logic [QE_W-1:0]   qf_c;
	logic [W_W-1:0]    w_c;
	logic [PW_W-1:0]   pw_c;

	assign p_sel = cfg.ve_mode ? in_q : P_W'(in_sb.dir);
	assign pc_sh = pc_s1[PC_W-1:12];
	assign u_c   = v_s3[V_W-1:3];
	assign qe_c  = prod_s4[PR_W-1:RECIP_SH];
	assign r_c   = R_W'(u_s4) - R_W'(qe_c) * R_W'(DIV_125);
	assign qf_c  = (r_c >= R_W'(DIV_125)) ? (qe_c + QE_W'(1)) : qe_c;
	assign w_c   = pl_s5[PL_W-1:8];

	always_comb begin
		if (w_c < W_W'(PW_MIN)) begin
			pw_c = PW_W'(PW_MIN);
		end else if (w_c > W_W'(cfg.lim_us)) begin
			pw_c = cfg.lim_us;
		end else begin
			pw_c = w_c[PW_W-1:0];
		end
		if (sb_s5.cut) begin
			pw_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[4:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			pc_s1   <= PC_W'(p_sel) * PC_W'(in_sb.corr);
			sb_s1   <= in_sb;

			// anything at or above 2^23 clamps to the pulse limit anyway
			ps_s2   <= (pc_sh >= (PC_W-12)'(1) << P_SAT_BIT) ?
			           PS_W'(1) << P_SAT_BIT : pc_sh[PS_W-1:0];
			en_s2   <= sb_s1.launch && (sb_s1.lpct > LPCT_W'(LAUNCH_MIN));
			mf_s2   <= MF_W'(LAUNCH_BASE) + MF_W'(sb_s1.lpct);
			sb_s2   <= sb_s1;

			v_s3    <= V_W'(ps_s2) * V_W'(mf_s2);
			ps_s3   <= ps_s2;
			en_s3   <= en_s2;
			sb_s3   <= sb_s2;

			prod_s4 <= PR_W'(u_c) * PR_W'(RECIP_125);
			u_s4    <= u_c;
			ps_s4   <= ps_s3;
			en_s4   <= en_s3;
			sb_s4   <= sb_s3;

			pl_s5   <= en_s4 ? qf_c : PL_W'(ps_s4);
			sb_s5   <= sb_s4;

			pw_s6   <= pw_c;
			disp_s6 <= sb_s5.disp;
		end
	end

	assign out_vld        = vld_s[5];
	assign pulse_width_us = pw_s6;
	assign ve_display     = disp_s6;

endmodule

FILE: rtl/fuel_pulse_width_calc.sv
`timescale 1ns / 1ps
// Takes 1 request per cycle except while m_axis_tvalid waits on m_axis_tready or cfg.busy is set.
// Depth is set by two bit-per-stage dividers (29 and 39 stages) plus 12 stages.
// After reset and after every config write the flow factor is recomputed
// (bit-serial divide, then square root); s_axis_tready is low meanwhile.
// Reset is asynchronous, active low; it restores register defaults and
// clears all valid bits.
// ----------------------------------------------------------------------------
// fuel_pulse_width_calc: speed-density injector pulse width
// Front stages clamp inputs and build the base-width numerator, then two
// pipelined dividers and the correction back end produce the pulse.
// ----------------------------------------------------------------------------
module fuel_pulse_width_calc import fpw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// fields from bit 0: cell_value[15:0], manifold_kpa[27:16], intake_temp[39:28],
	// correction[55:40], launch_active[56], launch_pct[66:57], fuel_cut[67]
	input  logic [71:0]           s_axis_tdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// fields from bit 0: pulse_width_us[14:0], ve_display[30:15]
	output logic [31:0]           m_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SB_W = $bits(side_t);

	cfg_t cfg;
	logic ce;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [CELL_W-1:0] cell_s1;
	logic [MAP_W-1:0]         map_s1;
	logic signed [IAT_W-1:0]  iat_s1;
	logic [CORR_W-1:0]        corr_s1;
	logic                     launch_s1;
	logic [LPCT_W-1:0]        lpct_s1;
	logic                     cut_s1;

	logic [VE_W-1:0]   ve_s2;
	logic [MAP_W-1:0]  map_s2;
	logic [T_W-1:0]    t_s2;
	side_t             sb_s2;
	logic [VE_W+REQ_W-1:0] rv_s3;
	logic [DEN1_W-1:0] den_s3;
	logic [MAP_W-1:0]  map_s3;
	side_t             sb_s3;
	logic [38:0]       rvm_s4;
	logic [DEN1_W-1:0] den_s4;
	side_t             sb_s4;
	logic [NUM1_W-1:0] num_s5;
	logic [DEN1_W-1:0] den_s5;
	side_t             sb_s5;
	logic [M_W-1:0]    m_s6;
	side_t             sb_s6;

	logic [VE_W-1:0]   ve_c;
	logic signed [17:0] t_full;
	logic [T_W-1:0]    t_c;
	logic [MAP_W-1:0]  map_c;
	side_t             sb_c;

	logic              d1_vld;
	logic [B_W-1:0]    d1_q;
	logic [SB_W-1:0]   d1_sb;
	logic              d2_vld;
	logic [P_W-1:0]    d2_q;
	logic [SB_W-1:0]   d2_sb;

	logic [PW_W-1:0]          pulse_width_us;
	logic signed [CELL_W-1:0] ve_display;

	fpw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cfg_ready     = 1'b1;
	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce && !cfg.busy;

	// stage 1: capture request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= s_axis_tvalid && s_axis_tready;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= d1_vld;
		end
	end

	always_comb begin
		if (cell_s1[CELL_W-1]) begin
			ve_c = '0;
		end else if (cell_s1 > 16'sd15000) begin
			ve_c = VE_W'(VE_MAX);
		end else begin
			ve_c = cell_s1[VE_W-1:0];
		end
	end

	assign t_full = $signed({{6{iat_s1[IAT_W-1]}}, iat_s1}) * 18'sd10 + 18'sd27315;
	assign t_c    = (t_full < 18'sd25000) ? T_W'(T_MIN) : t_full[T_W-1:0];
	assign map_c  = (map_s1 < MAP_W'(MAP_MIN)) ? MAP_W'(MAP_MIN) : map_s1;

	always_comb begin
		sb_c.disp   = cfg.ve_mode ? $signed({2'b00, ve_c}) : cell_s1;
		sb_c.dir    = (!cell_s1[CELL_W-1] && cell_s1 != '0) ?
		              DIR_W'(cell_s1[CELL_W-2:0]) * DIR_W'(DIRECT_GAIN) : '0;
		sb_c.corr   = corr_s1;
		sb_c.launch = launch_s1;
		sb_c.lpct   = lpct_s1;
		sb_c.cut    = cut_s1;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cell_s1   <= s_axis_tdata[15:0];
			map_s1    <= s_axis_tdata[27:16];
			iat_s1    <= s_axis_tdata[39:28];
			corr_s1   <= s_axis_tdata[55:40];
			launch_s1 <= s_axis_tdata[56];
			lpct_s1   <= s_axis_tdata[66:57];
			cut_s1    <= s_axis_tdata[67];

			ve_s2  <= ve_c;
			map_s2 <= map_c;
			t_s2   <= t_c;
			sb_s2  <= sb_c;

			rv_s3  <= (VE_W+REQ_W)'(cfg.req) * (VE_W+REQ_W)'(ve_s2);
			den_s3 <= DEN1_W'(t_s2) * DEN1_W'(D_SCALE);
			map_s3 <= map_s2;
			sb_s3  <= sb_s2;

			rvm_s4 <= 39'(rv_s3) * 39'(map_s3);
			den_s4 <= den_s3;
			sb_s4  <= sb_s3;

			num_s5 <= {54'(rvm_s4) * 54'(AIR_K), 8'd0};
			den_s5 <= den_s4;
			sb_s5  <= sb_s4;

			m_s6   <= M_W'(d1_q) * M_W'(cfg.k);
			sb_s6  <= side_t'(d1_sb);
		end
	end

	// base width in Q8 microseconds
	fpw_div #(
		.NUM_W (NUM1_W),
		.DEN_W (DEN1_W),
		.Q_W   (B_W),
		.SB_W  (SB_W)
	) u_div_base (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (vld_s5),
		.in_num  (num_s5),
		.in_den  (den_s5),
		.in_sb   (sb_s5),
		.out_vld (d1_vld),
		.out_q   (d1_q),
		.out_sb  (d1_sb)
	);

	// flow scaling: (b * k / 65536) / flow
	fpw_div #(
		.NUM_W (NUM2_W),
		.DEN_W (FLOW_W),
		.Q_W   (P_W),
		.SB_W  (SB_W)
	) u_div_flow (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (vld_s6),
		.in_num  (m_s6[M_W-1:16]),
		.in_den  (cfg.flow),
		.in_sb   (sb_s6),
		.out_vld (d2_vld),
		.out_q   (d2_q),
		.out_sb  (d2_sb)
	);

	fpw_post u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.ce             (ce),
		.cfg            (cfg),
		.in_vld         (d2_vld),
		.in_q           (d2_q),
		.in_sb          (side_t'(d2_sb)),
		.out_vld        (m_axis_tvalid),
		.pulse_width_us (pulse_width_us),
		.ve_display     (ve_display)
	);

	assign m_axis_tdata = {1'b0, ve_display, pulse_width_us};

`ifndef SYNTHESIS
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.busy |-> !s_axis_tready)
		else $error("request accepted while flow factor recomputes");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> cfg.busy)
		else $error("config write did not restart factor computation");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (pulse_width_us == '0) ||
		((pulse_width_us >= PW_W'(PW_MIN)) && (pulse_width_us <= cfg.lim_us)))
		else $error("pulse width outside clamp range");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for fuel_pulse_width_calc
// Streams directed and random fuel requests through several register
// settings and compares each result with a local pulse width computation.
// ----------------------------------------------------------------------------
module tb;
	import fpw_pkg::*;

	typedef struct packed {
		logic                     fuel_cut;
		logic [LPCT_W-1:0]        launch_pct;
		logic                     launch_active;
		logic [CORR_W-1:0]        correction;
		logic signed [IAT_W-1:0]  intake_temp;
		logic [MAP_W-1:0]         manifold_kpa;
		logic signed [CELL_W-1:0] cell_val;
	} fuel_req_t;

	typedef struct packed {
		logic signed [CELL_W-1:0] ve_display;
		logic [PW_W-1:0]          pulse_us;
	} pulse_t;

	localparam int REQ_BITS = $bits(fuel_req_t);

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [71:0]           s_axis_tdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           m_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fuel_pulse_width_calc uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// local copy of the registers
	logic        m_ve_mode = 1'b1;
	logic [12:0] m_req = 13'd1000;
	logic [13:0] m_rail = 14'd300;
	logic [13:0] m_rated = 14'd300;
	logic [10:0] m_flow = 11'd220;
	logic [9:0]  m_limit = 10'd200;

	fuel_req_t req_q[$];
	pulse_t    pulse_q[$];
	fuel_req_t cur_req;
	int        tx_gap = 0, rx_stall = 0, rx_hold = 0;
	bit        hold_done = 0, idle_on = 1;
	int        n_in = 0, n_out = 0, n_err = 0, n_cfg = 0, quiet = 0;

	function automatic pulse_t calc_pulse(fuel_req_t r);
		pulse_t res;
		int ve, t;
		longint unsigned b, rail, rated, flow, x, root, bt, p, lim, mp;
		if (m_ve_mode) begin
			ve = r.cell_val;
			if (ve < 0) ve = 0;
			if (ve > VE_MAX) ve = VE_MAX;
			res.ve_display = CELL_W'(ve);
			mp = (r.manifold_kpa < MAP_MIN) ? MAP_MIN : r.manifold_kpa;
			t = int'(r.intake_temp) * 10 + T_OFS;
			if (t < T_MIN) t = T_MIN;
			b = 64'(m_req) * 64'(ve) * mp * 64'(AIR_K) * 64'd256;
			b = b / (64'(D_SCALE) * 64'(t));
			rail = (m_rail < PRESS_MIN) ? PRESS_MIN : m_rail;
			rated = (m_rated < PRESS_MIN) ? PRESS_MIN : m_rated;
			flow = (m_flow < FLOW_MIN) ? FLOW_MIN : m_flow;
			// integer square root of the pressure ratio, Q16
			x = (rated << 32) / rail;
			root = 0;
			bt = 64'd1 << 62;
			while (bt > x) bt >>= 2;
			while (bt != 0) begin
				if (x >= root + bt) begin
					x -= root + bt;
					root = (root >> 1) + bt;
				end else begin
					root >>= 1;
				end
				bt >>= 2;
			end
			p = (b * FLOW_GAIN * root) / (flow * 64'd65536);
		end else begin
			res.ve_display = r.cell_val;
			p = (r.cell_val > 0) ? 64'(r.cell_val) * DIRECT_GAIN : 0;
		end
		p = (p * r.correction) / 4096;
		if (r.launch_active && r.launch_pct > LAUNCH_MIN)
			p = (p * (LAUNCH_BASE + r.launch_pct)) / LAUNCH_BASE;
		p = p / 256;
		lim = m_limit;
		if (lim < LIM_MIN) lim = LIM_MIN;
		if (lim > LIM_MAX) lim = LIM_MAX;
		lim = lim * LIM_SCALE;
		if (p < PW_MIN) p = PW_MIN;
		if (p > lim) p = lim;
		if (r.fuel_cut) p = 0;
		res.pulse_us = p[PW_W-1:0];
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch on result %0d: %s got %0d expected %0d", n_out, what, got, want);
		n_err++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				pulse_q.push_back(calc_pulse(cur_req));
				n_in++;
				busy = 0;
				tx_gap = pick_gap();
			end
			if (!busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (req_q.size() > 0) begin
					cur_req = req_q.pop_front();
					s_axis_tdata <= {4'b0, cur_req};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor, receiver stalls and watchdog
	always @(posedge clk or negedge arst_n) begin
		pulse_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= 20000) begin
				$display("CHECKS FAILED");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[30:0];
				n_out++;
				if (pulse_q.size() == 0) begin
					report("result with none pending", got.pulse_us, 0);
				end else begin
					want = pulse_q.pop_front();
					if (got.pulse_us !== want.pulse_us)
						report("pulse_width_us", got.pulse_us, want.pulse_us);
					if (got.ve_display !== want.ve_display)
						report("ve_display", got.ve_display, want.ve_display);
				end
				rx_stall = pick_gap();
				// one long hold-off so the pipeline backs up into the input
				if (n_out == 200 && !hold_done) begin
					hold_done = 1;
					rx_hold = 400;
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_VE_MODE:        m_ve_mode = val[0];
			REG_REQUIRED_FUEL:  m_req = val[12:0];
			REG_RAIL_PRESSURE:  m_rail = val[13:0];
			REG_RATED_PRESSURE: m_rated = val[13:0];
			REG_INJECTOR_FLOW:  m_flow = val[10:0];
			REG_PULSE_LIMIT:    m_limit = val[9:0];
			default: ;
		endcase
		n_cfg++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (req_q.size() > 0 || s_axis_tvalid || pulse_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic fuel_req_t rand_req();
		fuel_req_t r;
		r = REQ_BITS'({$urandom, $urandom, $urandom});
		r.correction = CORR_W'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			r.cell_val = CELL_W'($urandom_range(0, 40000) - 10000);
			r.manifold_kpa = MAP_W'($urandom_range(0, 4000));
			r.intake_temp = IAT_W'($urandom_range(0, 1900) - 400);
			r.correction = CORR_W'($urandom_range(2048, 8192));
			r.launch_active = 1'($urandom_range(0, 1));
			r.launch_pct = LPCT_W'($urandom_range(0, 1000));
			r.fuel_cut = ($urandom_range(0, 15) == 0);
		end
		return r;
	endfunction

	task automatic add_req(int cv, int mp, int tmp, int corr, bit la, int lp, bit cut);
		fuel_req_t r;
		r.cell_val = CELL_W'(cv);
		r.manifold_kpa = MAP_W'(mp);
		r.intake_temp = IAT_W'(tmp);
		r.correction = CORR_W'(corr);
		r.launch_active = la;
		r.launch_pct = LPCT_W'(lp);
		r.fuel_cut = cut;
		req_q.push_back(r);
	endtask

	task automatic add_directed();
		add_req(-32768, 0, -2048, 4096, 0, 0, 0);
		add_req(-1, 1000, 200, 4096, 0, 0, 0);
		add_req(0, 1000, 200, 4096, 0, 0, 0);
		add_req(10000, 1000, 200, 4096, 0, 0, 0);
		add_req(15000, 1000, 200, 4096, 0, 0, 0);
		add_req(15001, 1000, 200, 4096, 0, 0, 0);
		add_req(32767, 4095, 2047, 65535, 1, 1023, 0);
		add_req(9000, 199, -400, 4096, 0, 0, 0);
		add_req(9000, 200, -232, 4096, 0, 0, 0);
		add_req(9000, 4000, 1500, 0, 0, 0, 0);
		add_req(9000, 1000, 200, 4096, 1, 1, 0);
		add_req(9000, 1000, 200, 4096, 1, 2, 0);
		add_req(9000, 1000, 200, 4096, 0, 500, 0);
		add_req(9000, 1000, 200, 4096, 1, 1000, 1);
		add_req(300, 1000, 200, 4096, 0, 0, 0);
		add_req(2000, 3000, 0, 12000, 1, 300, 0);
	endtask

	task automatic run_phase(bit directed, int count, bit idle);
		idle_on = idle;
		if (directed) add_directed();
		repeat (count) req_q.push_back(rand_req());
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_phase(1, 130, 1);

		write_reg(REG_VE_MODE, 0);
		write_reg(REG_PULSE_LIMIT, 300);
		run_phase(1, 130, 0);

		write_reg(REG_VE_MODE, 1);
		write_reg(REG_REQUIRED_FUEL, 5000);
		write_reg(REG_RAIL_PRESSURE, 10000);
		write_reg(REG_RATED_PRESSURE, 0);
		write_reg(REG_INJECTOR_FLOW, 0);
		write_reg(REG_PULSE_LIMIT, 0);
		run_phase(1, 130, 1);

		write_reg(REG_REQUIRED_FUEL, 8191);
		write_reg(REG_RAIL_PRESSURE, 0);
		write_reg(REG_RATED_PRESSURE, 16383);
		write_reg(REG_INJECTOR_FLOW, 2047);
		write_reg(REG_PULSE_LIMIT, 1023);
		run_phase(0, 130, 1);

		// unused indexes must leave the registers alone
		write_reg(REG_SPARE_6, 16383);
		write_reg(REG_SPARE_7, 0);
		write_reg(REG_REQUIRED_FUEL, 0);
		write_reg(REG_PULSE_LIMIT, 9);
		run_phase(0, 40, 1);

		repeat (3) begin
			write_reg(REG_VE_MODE, $urandom_range(0, 1));
			write_reg(REG_REQUIRED_FUEL, $urandom_range(0, 5000));
			write_reg(REG_RAIL_PRESSURE, $urandom_range(0, 10000));
			write_reg(REG_RATED_PRESSURE, $urandom_range(0, 10000));
			write_reg(REG_INJECTOR_FLOW, $urandom_range(0, 2000));
			write_reg(REG_PULSE_LIMIT, $urandom_range(0, 1000));
			run_phase(1, 40, 1);
		end

		repeat (100) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d register writes", n_in, n_out, n_cfg);
		$display("VE and direct modes, clamp limits, floors, launch and fuel cut");
		if (n_err == 0 && pulse_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
